FILE: hw/rtl/bent_wall_contact_test_unit_assert.svh
// Assertion macros for the bent wall contact test unit.
`ifndef BENT_WALL_CONTACT_TEST_UNIT_ASSERT_SVH
`define BENT_WALL_CONTACT_TEST_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define BWCT_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bwct assertion failed");

// Antecedent implies consequent in the next cycle.
`define BWCT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bwct assertion failed");

`endif

FILE: hw/rtl/bwct_pkg.sv
// Shared constants and types for the bent wall contact test unit.
package bwct_pkg;

   // fixed point format of positions
   localparam int FRAC_BITS   = 16;
   localparam int Q14_SHIFT   = 14;
   localparam int ONE_Q14     = 16384;
   localparam int HALF_Q14    = 8192;

   // half size cube root: floor(cbrt(volume << CBRT_SHIFT))
   localparam int VOL_W       = 32;
   localparam int CBRT_SHIFT  = 2 * FRAC_BITS - 3;
   localparam int CBRT_XW     = VOL_W + CBRT_SHIFT;
   localparam int CBRT_RB     = (CBRT_XW + 2) / 3;

   // arc distance square root over dx^2 + dy^2
   localparam int SQ_XW       = 66;
   localparam int SQ_RB       = SQ_XW / 2;

   // normal divider: ((a << 14) + norm/2) / norm, quotient at most 1.0 in Q1.14
   localparam int DIV_QB      = Q14_SHIFT + 1;
   localparam int DIV_NW      = 33 + Q14_SHIFT + 1;

   // configuration register indexes
   localparam logic [2:0] CSR_FLOOR_HEIGHT   = 3'd0;
   localparam logic [2:0] CSR_ARC_CENTER_X   = 3'd1;
   localparam logic [2:0] CSR_ARC_CENTER_Y   = 3'd2;
   localparam logic [2:0] CSR_ARC_RADIUS     = 3'd3;
   localparam logic [2:0] CSR_SLOPE_SIN      = 3'd4;
   localparam logic [2:0] CSR_SLOPE_COS      = 3'd5;
   localparam logic [2:0] CSR_SLANT_ORIGIN_X = 3'd6;
   localparam logic [2:0] CSR_SLANT_ORIGIN_Y = 3'd7;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_FLOOR = 2'd1,
      KIND_SLANT = 2'd2,
      KIND_ARC   = 2'd3
   } bwct_kind_type;

endpackage

FILE: hw/rtl/bwct_delay.sv
// Enabled shift line that carries side data alongside a pipelined unit.
module bwct_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   if (DEPTH == 0) begin : g_wire
      assign dout = din;
   end else begin : g_line
      logic [WIDTH-1:0] tap_ff [DEPTH];

      always_ff @(posedge clock) begin
         if (en) begin
            tap_ff[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
               tap_ff[i] <= tap_ff[i-1];
            end
         end
      end

      assign dout = tap_ff[DEPTH-1];
   end
endmodule

FILE: hw/rtl/bwct_cbrt_pipe.sv
// Pipelined bitwise integer cube root, one result bit per stage.
module bwct_cbrt_pipe (
   input  logic                          clock,
   input  logic                          en,
   input  logic [bwct_pkg::VOL_W-1:0]    vol,
   output logic [bwct_pkg::CBRT_RB-1:0]  root
);
   import bwct_pkg::*;

   localparam int RB = CBRT_RB;
   localparam int XW = CBRT_XW;
   localparam int DW = 3 * RB + 2;

   logic [RB-1:0]   r_src   [RB+1];
   logic [2*RB-1:0] r2_src  [RB+1];
   logic [XW-1:0]   rem_src [RB+1];

   logic [RB-1:0]   r_ff    [RB];
   logic [2*RB-1:0] r2_ff   [RB];
   logic [XW-1:0]   rem_ff  [RB];

   // radicand is volume scaled so the root is half the size in Q(FRAC_BITS)
   assign r_src[0]   = '0;
   assign r2_src[0]  = '0;
   assign rem_src[0] = {vol, {CBRT_SHIFT{1'b0}}};

   for (genvar i = 0; i < RB; i++) begin : g_stage
      localparam int B = RB - 1 - i;
      logic [DW-1:0]   d_w;
      logic            take_w;
      logic [RB-1:0]   r_in;
      logic [2*RB-1:0] r2_in;
      logic [XW-1:0]   rem_in;

      // (r + 2^B)^3 - r^3 = 3 r^2 2^B + 3 r 2^2B + 2^3B, against rem = x - r^3
      always_comb begin
         d_w = (DW'(r2_src[i]) << (B + 1)) + (DW'(r2_src[i]) << B)
             + (DW'(r_src[i]) << (2 * B + 1)) + (DW'(r_src[i]) << (2 * B))
             + (DW'(1) << (3 * B));
         take_w = d_w <= DW'(rem_src[i]);
         if (take_w) begin
            r_in   = r_src[i] | (RB'(1) << B);
            r2_in  = r2_src[i] + ((2*RB)'(r_src[i]) << (B + 1)) + ((2*RB)'(1) << (2 * B));
            rem_in = rem_src[i] - XW'(d_w);
         end else begin
            r_in   = r_src[i];
            r2_in  = r2_src[i];
            rem_in = rem_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i]   <= r_in;
            r2_ff[i]  <= r2_in;
            rem_ff[i] <= rem_in;
         end
      end

      assign r_src[i+1]   = r_ff[i];
      assign r2_src[i+1]  = r2_ff[i];
      assign rem_src[i+1] = rem_ff[i];
   end

   assign root = r_src[RB];
endmodule

FILE: hw/rtl/bwct_sqrt_pipe.sv
// Pipelined bitwise integer square root, one result bit per stage.
module bwct_sqrt_pipe (
   input  logic                        clock,
   input  logic                        en,
   input  logic [bwct_pkg::SQ_XW-1:0]  radicand,
   output logic [bwct_pkg::SQ_RB-1:0]  root
);
   import bwct_pkg::*;

   localparam int RB = SQ_RB;
   localparam int XW = SQ_XW;
   localparam int DW = 2 * RB + 2;

   logic [RB-1:0] r_src   [RB+1];
   logic [XW-1:0] rem_src [RB+1];
   logic [RB-1:0] r_ff    [RB];
   logic [XW-1:0] rem_ff  [RB];

   assign r_src[0]   = '0;
   assign rem_src[0] = radicand;

   for (genvar i = 0; i < RB; i++) begin : g_stage
      localparam int B = RB - 1 - i;
      logic [DW-1:0] d_w;
      logic          take_w;
      logic [RB-1:0] r_in;
      logic [XW-1:0] rem_in;

      // (r + 2^B)^2 - r^2 = r 2^(B+1) + 2^2B, against rem = x - r^2
      always_comb begin
         d_w    = (DW'(r_src[i]) << (B + 1)) | (DW'(1) << (2 * B));
         take_w = d_w <= DW'(rem_src[i]);
         r_in   = take_w ? (r_src[i] | (RB'(1) << B)) : r_src[i];
         rem_in = take_w ? (rem_src[i] - XW'(d_w)) : rem_src[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i]   <= r_in;
            rem_ff[i] <= rem_in;
         end
      end

      assign r_src[i+1]   = r_ff[i];
      assign rem_src[i+1] = rem_ff[i];
   end

   assign root = r_src[RB];
endmodule

FILE: hw/rtl/bwct_div_pipe.sv
// Pipelined restoring divider for the Q1.14 arc normal components.
module bwct_div_pipe (
   input  logic                         clock,
   input  logic                         en,
   input  logic [bwct_pkg::DIV_NW-1:0]  num,
   input  logic [bwct_pkg::SQ_RB-1:0]   den,
   output logic [bwct_pkg::DIV_QB-1:0]  quo
);
   import bwct_pkg::*;

   localparam int QB = DIV_QB;
   localparam int NW = DIV_NW;
   localparam int DB = SQ_RB;

   logic [NW-1:0] rem_src [QB+1];
   logic [DB-1:0] den_src [QB+1];
   logic [QB-1:0] q_src   [QB+1];
   logic [NW-1:0] rem_ff  [QB];
   logic [DB-1:0] den_ff  [QB];
   logic [QB-1:0] q_ff    [QB];

   assign rem_src[0] = num;
   assign den_src[0] = den;
   assign q_src[0]   = '0;

   for (genvar i = 0; i < QB; i++) begin : g_stage
      localparam int B = QB - 1 - i;
      logic [NW-1:0] dsh_w;
      logic          take_w;
      logic [NW-1:0] rem_in;
      logic [QB-1:0] q_in;

      // quotient never reaches 2^QB, so each trial subtract is exact
      always_comb begin
         dsh_w  = NW'(den_src[i]) << B;
         take_w = rem_src[i] >= dsh_w;
         rem_in = take_w ? (rem_src[i] - dsh_w) : rem_src[i];
         q_in   = take_w ? (q_src[i] | (QB'(1) << B)) : q_src[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src[i];
            q_ff[i]   <= q_in;
         end
      end

      assign rem_src[i+1] = rem_ff[i];
      assign den_src[i+1] = den_ff[i];
      assign q_src[i+1]   = q_ff[i];
   end

   assign quo = q_src[QB];
endmodule

FILE: hw/rtl/bent_wall_contact_test_unit.sv
// Bent wall contact test: one particle against a floor, a concave arc and a slanted plane.
// Accepts one particle per clock unless stalled and returns one result beat per particle,
// in order. Pipe: three front stages (offsets, products, sums), the 33-stage square root
// of the arc distance, one selection stage, the 15-stage dividers that form the arc
// normal, and the output register. The 21-stage half-size cube root starts with the
// front stages; a delay line lines its result up with the square root output. A stall
// on a valid result freezes the whole pipe and is passed straight back as req_stall.
// Configuration must be written only while idle; the block does not enforce it.
module bent_wall_contact_test_unit (
   input  logic                clock,
   input  logic                reset,
   // particle beats
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic [31:0]         req_volume,
   // result beats
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_contact_kind,
   output logic signed [31:0]  rsp_overlap,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   // configuration writes
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import bwct_pkg::*;

   localparam int LAT     = 5 + SQ_RB + DIV_QB;
   localparam int LEN_DLY = 3 + SQ_RB - CBRT_RB;
   localparam int DSTW    = 38;
   localparam logic signed [DSTW-1:0] OV_MIN = $signed({{(DSTW-31){1'b1}}, 31'b0});

   typedef struct packed {
      logic               wedge;
      logic signed [32:0] base1;
      logic signed [35:0] base2;
      logic [32:0]        ax;
      logic [32:0]        ay;
   } arc_side_type;

   typedef struct packed {
      bwct_kind_type      kind;
      logic signed [31:0] ov;
   } sel_side_type;

   // configuration registers
   logic signed [31:0] floor_height_ff, arc_cx_ff, arc_cy_ff, slant_ox_ff, slant_oy_ff;
   logic [30:0]        arc_radius_ff;
   logic [14:0]        slope_sin_ff, slope_cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_height_ff <= '0;
         arc_cx_ff       <= '0;
         arc_cy_ff       <= '0;
         arc_radius_ff   <= '0;
         slope_sin_ff    <= '0;
         slope_cos_ff    <= 15'(ONE_Q14);
         slant_ox_ff     <= '0;
         slant_oy_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FLOOR_HEIGHT:   floor_height_ff <= csr_data;
            CSR_ARC_CENTER_X:   arc_cx_ff       <= csr_data;
            CSR_ARC_CENTER_Y:   arc_cy_ff       <= csr_data;
            CSR_ARC_RADIUS:     arc_radius_ff   <= csr_data[30:0];
            CSR_SLOPE_SIN:      slope_sin_ff    <= csr_data[14:0];
            CSR_SLOPE_COS:      slope_cos_ff    <= csr_data[14:0];
            CSR_SLANT_ORIGIN_X: slant_ox_ff     <= csr_data;
            CSR_SLANT_ORIGIN_Y: slant_oy_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: the pipe moves unless a finished beat is held
   logic en;
   logic [LAT-1:0] vld_ff;

   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: offsets from the arc centre, slant origin and floor
   logic signed [32:0] s1_dxa_ff, s1_dya_ff, s1_dxs_ff, s1_dys_ff, s1_base1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dxa_ff   <= 33'(req_pos_x) - 33'(arc_cx_ff);
         s1_dya_ff   <= 33'(req_pos_y) - 33'(arc_cy_ff);
         s1_dxs_ff   <= 33'(req_pos_x) - 33'(slant_ox_ff);
         s1_dys_ff   <= 33'(req_pos_y) - 33'(slant_oy_ff);
         s1_base1_ff <= 33'(req_pos_y) - 33'(floor_height_ff);
      end
   end

   // stage 2: squares, wedge products and slant dot products
   logic [32:0]        ax_w, ay_w;
   logic [65:0]        s2_sqx_ff, s2_sqy_ff;
   logic [47:0]        s2_pwx_ff, s2_pwy_ff;
   logic signed [48:0] s2_dsx_ff, s2_dsy_ff;
   logic               s2_negx_ff, s2_negy_ff;
   logic signed [32:0] s2_base1_ff;
   logic [32:0]        s2_ax_ff, s2_ay_ff;

   assign ax_w = 33'(-s1_dxa_ff);
   assign ay_w = 33'(-s1_dya_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sqx_ff   <= ax_w * ax_w;
         s2_sqy_ff   <= ay_w * ay_w;
         s2_pwx_ff   <= ax_w * slope_cos_ff;
         s2_pwy_ff   <= ay_w * slope_sin_ff;
         s2_dsx_ff   <= s1_dxs_ff * $signed({1'b0, slope_sin_ff});
         s2_dsy_ff   <= s1_dys_ff * $signed({1'b0, slope_cos_ff});
         s2_negx_ff  <= s1_dxa_ff[32];
         s2_negy_ff  <= s1_dya_ff[32];
         s2_base1_ff <= s1_base1_ff;
         s2_ax_ff    <= ax_w;
         s2_ay_ff    <= ay_w;
      end
   end

   // stage 3: sum of squares, wedge test, rounded slant distance
   logic signed [49:0] dot_w;
   logic [SQ_XW-1:0]   s3_sumsq_ff;
   arc_side_type       s3_side_ff;

   assign dot_w = 50'(s2_dsx_ff) + 50'(s2_dsy_ff) + 50'(HALF_Q14);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sumsq_ff       <= SQ_XW'(s2_sqx_ff) + SQ_XW'(s2_sqy_ff);
         s3_side_ff.wedge  <= s2_negx_ff && s2_negy_ff && (s2_pwx_ff < s2_pwy_ff);
         s3_side_ff.base1  <= s2_base1_ff;
         s3_side_ff.base2  <= 36'(dot_w >>> Q14_SHIFT);
         s3_side_ff.ax     <= s2_ax_ff;
         s3_side_ff.ay     <= s2_ay_ff;
      end
   end

   // half size, aligned to the square root output
   logic [CBRT_RB-1:0] len_w, len_d;

   bwct_cbrt_pipe u_cbrt (
      .clock (clock),
      .en    (en),
      .vol   (req_volume),
      .root  (len_w)
   );

   bwct_delay #(.WIDTH(CBRT_RB), .DEPTH(LEN_DLY)) u_len_dly (
      .clock (clock),
      .en    (en),
      .din   (len_w),
      .dout  (len_d)
   );

   // arc distance
   logic [SQ_RB-1:0] norm_w;
   arc_side_type     side_d;

   bwct_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s3_sumsq_ff),
      .root     (norm_w)
   );

   bwct_delay #(.WIDTH($bits(arc_side_type)), .DEPTH(SQ_RB)) u_side_dly (
      .clock (clock),
      .en    (en),
      .din   (s3_side_ff),
      .dout  (side_d)
   );

   // selection stage: distances, priority, saturation, normal numerators
   logic signed [DSTW-1:0] len_s_w, d_arc_w, d_floor_w, d_slant_w, ov_w;
   sel_side_type           sel_w, sd_sel_ff;
   logic [DIV_NW-1:0]      sd_numx_ff, sd_numy_ff;
   logic [SQ_RB-1:0]       sd_norm_ff;

   always_comb begin
      len_s_w   = $signed(DSTW'(len_d));
      d_arc_w   = $signed(DSTW'(arc_radius_ff)) - $signed(DSTW'(norm_w)) - len_s_w;
      d_floor_w = DSTW'(side_d.base1) - len_s_w;
      d_slant_w = DSTW'(side_d.base2) - len_s_w;
      if (side_d.wedge && d_arc_w < 0) begin
         sel_w.kind = KIND_ARC;
         ov_w       = d_arc_w;
      end else if (d_floor_w < 0) begin
         sel_w.kind = KIND_FLOOR;
         ov_w       = d_floor_w;
      end else if (d_slant_w < 0) begin
         sel_w.kind = KIND_SLANT;
         ov_w       = d_slant_w;
      end else begin
         sel_w.kind = KIND_NONE;
         ov_w       = '0;
      end
      sel_w.ov = (ov_w < OV_MIN) ? 32'sh8000_0000 : ov_w[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_sel_ff  <= sel_w;
         sd_numx_ff <= (DIV_NW'(side_d.ax) << Q14_SHIFT) + DIV_NW'(norm_w >> 1);
         sd_numy_ff <= (DIV_NW'(side_d.ay) << Q14_SHIFT) + DIV_NW'(norm_w >> 1);
         sd_norm_ff <= norm_w;
      end
   end

   // arc normal components
   logic [DIV_QB-1:0] qx_w, qy_w;
   sel_side_type      sel_d;

   bwct_div_pipe u_div_x (
      .clock (clock),
      .en    (en),
      .num   (sd_numx_ff),
      .den   (sd_norm_ff),
      .quo   (qx_w)
   );

   bwct_div_pipe u_div_y (
      .clock (clock),
      .en    (en),
      .num   (sd_numy_ff),
      .den   (sd_norm_ff),
      .quo   (qy_w)
   );

   bwct_delay #(.WIDTH($bits(sel_side_type)), .DEPTH(DIV_QB)) u_sel_dly (
      .clock (clock),
      .en    (en),
      .din   (sd_sel_ff),
      .dout  (sel_d)
   );

   // output register
   bwct_kind_type      rsp_kind_ff;
   logic signed [31:0] rsp_overlap_ff;
   logic signed [15:0] rsp_nx_ff, rsp_ny_ff, nx_w, ny_w;

   always_comb begin
      case (sel_d.kind)
         KIND_ARC: begin
            nx_w = 16'(qx_w);
            ny_w = 16'(qy_w);
         end
         KIND_FLOOR: begin
            nx_w = '0;
            ny_w = 16'(ONE_Q14);
         end
         KIND_SLANT: begin
            nx_w = 16'(slope_sin_ff);
            ny_w = 16'(slope_cos_ff);
         end
         default: begin
            nx_w = '0;
            ny_w = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_kind_ff    <= sel_d.kind;
         rsp_overlap_ff <= sel_d.ov;
         rsp_nx_ff      <= nx_w;
         rsp_ny_ff      <= ny_w;
      end
   end

   assign rsp_contact_kind = rsp_kind_ff;
   assign rsp_overlap      = rsp_overlap_ff;
   assign rsp_normal_x     = rsp_nx_ff;
   assign rsp_normal_y     = rsp_ny_ff;

   // result consistency checks
   `include "bent_wall_contact_test_unit_assert.svh"

   `BWCT_ASSERT_IMPLIES(a_none_is_zero, clock, reset,
      rsp_valid && rsp_contact_kind == KIND_NONE,
      rsp_overlap == 0 && rsp_normal_x == 0 && rsp_normal_y == 0)
   `BWCT_ASSERT_IMPLIES(a_contact_negative, clock, reset,
      rsp_valid && rsp_contact_kind != KIND_NONE, rsp_overlap[31])
   `BWCT_ASSERT_IMPLIES(a_floor_normal, clock, reset,
      rsp_valid && rsp_contact_kind == KIND_FLOOR,
      rsp_normal_x == 0 && rsp_normal_y == 16'(ONE_Q14))
endmodule
